// ===== rtl/core/bkv_pkg.sv =====
// Package for the bounded key/value table: payload types, codes and control structs.
package bkv_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 9;
  localparam int POS_W     = 8;
  localparam int CMD_W     = 3;
  localparam int DEPTH_DEF = 256;

  // Capacity after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 9'd250;

  // Command codes; the two codes above read position answer with a failure.
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPSERT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_POS = 3'd5;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } bkv_req_t;

  // Result item.
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key_out;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] count;
  } bkv_rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_RDATA
  } bkv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input item and restart the walk pointer
    logic scan;       // key search step
    logic shift;      // erase compaction step
    logic rd_pos;     // read the entry at the requested position
    logic wr_val;     // overwrite the value of the matched entry
    logic append;     // write a new entry at the end, count up
    logic dec;        // count down after an erase
    logic done;       // register the result item
    logic ok;         // success flag of the result
    logic use_rd_key; // key_out from the read data
    logic use_rd_val; // value_out from the read data
  } bkv_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;      // read data matches the requested key
    logic             walk_end; // walk pointer at count and no read in flight
    logic             full;
    logic             pos_ok;
  } bkv_sts_t;

endpackage

// ===== rtl/core/bkv_datapath.sv =====
// Datapath of the key/value table: entry memories, walk pointer, count and result register.
module bkv_datapath
  import bkv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  bkv_req_t         in_req,
  input  bkv_ctl_t         ctl,
  output bkv_sts_t         sts,
  output logic             out_valid,
  output bkv_rsp_t         out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = (CNT_W > AW + 1) ? CNT_W : AW + 1;
  localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);

  // Entry storage, one write port and one registered read port each.
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];

  bkv_req_t         req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r;
  logic [IW-1:0]    scan_r, scan_nxt;
  logic             rd_pend_r;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  bkv_rsp_t         rsp_r, rsp_nxt;
  logic             out_valid_r;

  logic [IW-1:0]    count_i;
  logic [IW-1:0]    pos_i;
  logic             scan_lt;
  logic             hit;
  logic             pos_ok;
  logic             issue;
  logic             shift_wr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             key_we;
  logic             val_we;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;

  // Status toward the controller.
  assign count_i = IW'(count_r);
  assign pos_i   = IW'(req_r.position);
  assign scan_lt = scan_r < count_i;
  assign hit     = rd_pend_r && (rd_key_r == req_r.key);
  assign pos_ok  = pos_i < count_i;

  always_comb begin
    sts          = '0;
    sts.cmd      = req_r.cmd;
    sts.hit      = hit;
    sts.walk_end = !rd_pend_r && !scan_lt;
    sts.full     = (count_r >= cap_r) || (count_i >= DEPTH_I);
    sts.pos_ok   = pos_ok;
  end

  // Walk reads: one entry per cycle, stopping on a match during a search.
  assign issue    = ((ctl.scan && !hit) || ctl.shift) && scan_lt;
  assign shift_wr = ctl.shift && rd_pend_r;
  assign rd_en    = issue || (ctl.rd_pos && pos_ok);
  assign rd_addr  = ctl.rd_pos ? pos_i[AW-1:0] : scan_r[AW-1:0];

  // Write port: shifted entry, appended entry or updated value.
  assign key_we = shift_wr || ctl.append;
  assign val_we = shift_wr || ctl.append || ctl.wr_val;
  assign wr_key = shift_wr ? rd_key_r : req_r.key;
  assign wr_val = shift_wr ? rd_val_r : req_r.value;

  always_comb begin
    if (shift_wr) begin
      wr_addr = rd_addr_r - AW'(1);
    end else if (ctl.append) begin
      wr_addr = count_i[AW-1:0];
    end else begin
      wr_addr = rd_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  // Walk pointer and in-flight read tracking.
  always_comb begin
    scan_nxt    = scan_r;
    rd_addr_nxt = rd_addr_r;
    if (ctl.load) begin
      scan_nxt = '0;
    end else if (issue) begin
      scan_nxt    = scan_r + IW'(1);
      rd_addr_nxt = scan_r[AW-1:0];
    end
  end

  // Entry count after append or erase.
  always_comb begin
    count_nxt = count_r;
    if (ctl.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result item built from the request or the read data.
  always_comb begin
    rsp_nxt           = rsp_r;
    rsp_nxt.ok        = ctl.ok;
    rsp_nxt.key_out   = ctl.use_rd_key ? rd_key_r : req_r.key;
    rsp_nxt.value_out = ctl.use_rd_val ? rd_val_r : '0;
    rsp_nxt.count     = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      scan_r      <= '0;
      rd_pend_r   <= 1'b0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      rd_pend_r   <= issue && !ctl.load;
      rd_addr_r   <= rd_addr_nxt;
      out_valid_r <= ctl.done;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
    end
    if (ctl.done) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // The table never holds more entries than the memory has rows.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_i <= DEPTH_I)
    else $error("entry count exceeds the memory depth");

  // An entry is appended only while there is room.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> !sts.full)
    else $error("append issued on a full table");

  // An erase never counts below zero.
  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dec |-> (count_r != '0))
    else $error("erase on an empty table");

endmodule

// ===== rtl/core/bkv_controller.sv =====
// Controller state machine of the key/value table: sequences search, compaction and results.
module bkv_controller
  import bkv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bkv_sts_t sts,
  output bkv_ctl_t ctl
);

  bkv_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.cmd)
          CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE, CMD_LOOKUP: begin
            state_nxt = ST_SCAN;
          end
          CMD_READ_POS: begin
            ctl.rd_pos = 1'b1;
            state_nxt  = ST_RDATA;
          end
          default: begin
            // Unused codes answer at once with a failure.
            ctl.done  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.hit) begin
          // Key is present.
          case (sts.cmd)
            CMD_UPDATE, CMD_UPSERT: begin
              ctl.wr_val = 1'b1;
              ctl.ok     = 1'b1;
              ctl.done   = 1'b1;
              state_nxt  = ST_IDLE;
            end
            CMD_ERASE: begin
              state_nxt = ST_SHIFT;
            end
            CMD_LOOKUP: begin
              ctl.ok         = 1'b1;
              ctl.use_rd_val = 1'b1;
              ctl.done       = 1'b1;
              state_nxt      = ST_IDLE;
            end
            default: begin
              ctl.done  = 1'b1;
              state_nxt = ST_IDLE;
            end
          endcase
        end else if (sts.walk_end) begin
          // Key is absent; only the inserting commands may append.
          if ((sts.cmd == CMD_INSERT || sts.cmd == CMD_UPSERT) && !sts.full) begin
            ctl.append = 1'b1;
            ctl.ok     = 1'b1;
          end
          ctl.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        if (sts.walk_end) begin
          ctl.dec   = 1'b1;
          ctl.ok    = 1'b1;
          ctl.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RDATA: begin
        ctl.ok         = sts.pos_ok;
        ctl.use_rd_key = sts.pos_ok;
        ctl.use_rd_val = sts.pos_ok;
        ctl.done       = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // An accepted item always moves to decode.
  a_start_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_DISPATCH))
    else $error("accepted item did not reach decode");

  // Every result returns the controller to idle, so each item gives one result.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> (state_r == ST_IDLE))
    else $error("result registered without returning to idle");

endmodule

// ===== rtl/core/bounded_key_value_table.sv =====
// Top level of the bounded key/value table: controller and datapath.
//
// Usage: an item (cmd, key, value, position) is accepted on a rising edge
// with start high and busy low. busy stays high until the result is
// registered. The result item stays on out_rsp until the next result and
// is marked by out_valid for exactly one cycle; the receiver cannot stall it,
// and a new item may be started in the same cycle that the previous result is shown.
// Unused codes answer straight from decode, and read position reads the
// requested entry once. Key commands walk the entries one per cycle
// through the registered memory read port, stopping on a match or at the
// end of the entries. An erase on a match adds a compaction pass that moves
// each later entry down one row. A new item is not taken until the
// previous result is registered; the entry memories have a single read
// port and a single write port.
// Configuration: cfg_we with cfg_wdata writes capacity. The user must
// write capacity only while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the table and sets capacity to
// 250; the entry memories are not cleared and need no clearing pass.
module bounded_key_value_table
  import bkv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bkv_req_t         in_req,
  output logic             out_valid,
  output bkv_rsp_t         out_rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  bkv_ctl_t ctl;
  bkv_sts_t sts;

  // Command sequencing.
  bkv_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Storage and result path.
  bkv_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
